### hw/rtl/pts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
`default_nettype none

package pts_pkg;

	localparam int KIND_W      = 3;
	localparam int TASK_W      = 4;
	localparam int PERIOD_W    = 16;
	localparam int TICK_W      = 8;
	localparam int SLOTS_W     = 4;
	localparam int ELAPSED_W   = 17;
	localparam int IDX_OUT_W   = 3;
	localparam int REPLY_W     = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int MAX_RESULTS = 8;
	localparam int RES_CNT_W   = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [KIND_W-1:0] KIND_TICK       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_START      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SET_PERIOD = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;

	localparam logic [TICK_W-1:0]  TICK_MS_RESET      = 8'd100;
	localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RESET = 4'd8;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [TASK_W-1:0]   task_number;
		logic [PERIOD_W-1:0] period_ms;
		logic                mult_ok;
		logic                ge_tick;
	} pts_cmd_t;

	typedef struct packed {
		logic [TICK_W-1:0]  tick_ms;
		logic [SLOTS_W-1:0] slots_in_use;
	} pts_cfg_t;

	typedef struct packed {
		logic                 fired;
		logic [IDX_OUT_W-1:0] slot_index;
		logic [REPLY_W-1:0]   reply;
		logic                 last;
	} pts_res_t;

endpackage

`default_nettype wire

### hw/rtl/pts_ifs.sv
// Channel interfaces for requests, results and configuration writes.
`default_nettype none

interface pts_item_if;
	logic                          valid;
	logic                          ready;
	logic [pts_pkg::KIND_W-1:0]    kind;
	logic [pts_pkg::TASK_W-1:0]    task_number;
	logic [pts_pkg::PERIOD_W-1:0]  period_ms;
	modport source (output valid, kind, task_number, period_ms, input ready);
	modport sink (input valid, kind, task_number, period_ms, output ready);
endinterface

interface pts_result_if;
	logic                          valid;
	logic                          ready;
	logic                          fired;
	logic [pts_pkg::IDX_OUT_W-1:0] slot_index;
	logic [pts_pkg::REPLY_W-1:0]   reply;
	logic                          last;
	modport source (output valid, fired, slot_index, reply, last, input ready);
	modport sink (input valid, fired, slot_index, reply, last, output ready);
endinterface

interface pts_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pts_pkg::CFG_IDX_W-1:0]  index;
	logic [pts_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/periodic_task_tick_scheduler_unit.sv
// Top level of the periodic task tick scheduler with its configuration registers.
//
//   channel  direction  carries
//   items    in         kind, task_number, period_ms
//   results  out        fired, slot_index, reply, last
//   cfg      in         index, data (tick_ms, slots_in_use)
//
// In the slot engine a tick walks the registered slots in order, reading each slot in
// B_RD and checking it in B_EV; register and set-period requests go through the
// bit-serial remainder check in the front end, other requests pass straight on.
// The command queue lets the front end check the next item while a tick is walked.
// Reset clears the slot count, enable flags and all handshake state at once.
// A stalled result holds in the output register and a further fire waits behind it.
`default_nettype none

module periodic_task_tick_scheduler_unit #(
	parameter int MAX_SLOTS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pts_item_if.sink     items,
	pts_result_if.source results,
	pts_cfg_if.sink      cfg
);

	pts_pkg::pts_cfg_t  cfg_q;
	pts_pkg::pts_cmd_t  front_cmd;
	logic               front_valid;
	logic               front_ready;
	pts_pkg::pts_cmd_t  queue_cmd;
	logic               queue_valid;
	logic               queue_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_ms      <= pts_pkg::TICK_MS_RESET;
			cfg_q.slots_in_use <= pts_pkg::SLOTS_IN_USE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pts_pkg::CFG_TICK_MS:      cfg_q.tick_ms <= cfg.data;
				pts_pkg::CFG_SLOTS_IN_USE: cfg_q.slots_in_use <= cfg.data[pts_pkg::SLOTS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.tick_ms   (cfg_q.tick_ms),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	pts_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready),
		.pop_data   (queue_cmd)
	);

	pts_back #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd_ready (queue_ready),
		.cmd       (queue_cmd),
		.cfg       (cfg_q),
		.results   (results)
	);

	a_fire_no_reply: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.fired |-> results.reply == '0)
		else $error("A fire result carries a nonzero reply.");

	a_only_fires_continue: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.last |-> results.fired)
		else $error("A result that is not last is not a fire.");

	a_quiet_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.fired |-> results.slot_index == '0)
		else $error("A result without a fire names a slot.");

endmodule

`default_nettype wire

### hw/rtl/pts_front.sv
// Front end: accepts request items and checks periods against the tick.
`default_nettype none

module pts_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pts_item_if.sink                         items,
	input  wire logic [pts_pkg::TICK_W-1:0]  tick_ms,
	output pts_pkg::pts_cmd_t                cmd,
	output logic                             cmd_valid,
	input  wire logic                        cmd_ready
);

	localparam int STEP_W = $clog2(pts_pkg::PERIOD_W);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

	front_state_t                    state_q;
	pts_pkg::pts_cmd_t               cmd_q;
	logic [pts_pkg::TICK_W-1:0]      rem_q;
	logic [pts_pkg::PERIOD_W-1:0]    shf_q;
	logic [STEP_W-1:0]               cnt_q;
	logic [pts_pkg::TICK_W:0]        rem_sh;
	logic [pts_pkg::TICK_W-1:0]      rem_nx;
	logic                            accept;

	assign items.ready = (state_q == F_IDLE);
	assign accept      = items.valid && items.ready;
	assign cmd_valid   = (state_q == F_PUSH);
	assign cmd         = cmd_q;

	always_comb begin
		rem_sh = {rem_q, shf_q[pts_pkg::PERIOD_W-1]};
		if (rem_sh >= {1'b0, tick_ms}) begin
			rem_nx = pts_pkg::TICK_W'(rem_sh - {1'b0, tick_ms});
		end else begin
			rem_nx = rem_sh[pts_pkg::TICK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						cmd_q.kind        <= items.kind;
						cmd_q.task_number <= items.task_number;
						cmd_q.period_ms   <= items.period_ms;
						cmd_q.ge_tick     <= items.period_ms >= pts_pkg::PERIOD_W'(tick_ms);
						cmd_q.mult_ok     <= 1'b0;
						rem_q             <= '0;
						shf_q             <= items.period_ms;
						cnt_q             <= '1;
						if (items.kind == pts_pkg::KIND_REGISTER ||
						    items.kind == pts_pkg::KIND_SET_PERIOD) begin
							state_q <= F_DIV;
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_DIV: begin
					rem_q <= rem_nx;
					shf_q <= {shf_q[pts_pkg::PERIOD_W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						cmd_q.mult_ok <= (rem_nx == '0) && (tick_ms != '0);
						state_q       <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (cmd_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pts_fifo.sv
// Short command queue between the front end and the slot engine.
`default_nettype none

module pts_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire pts_pkg::pts_cmd_t push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output pts_pkg::pts_cmd_t      pop_data
);

	localparam int DEPTH = pts_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pts_pkg::pts_cmd_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pts_back.sv
// Slot engine: holds the task table, runs requests and walks slots on ticks.
`default_nettype none

module pts_back #(
	parameter int MAX_SLOTS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_ready,
	input  wire pts_pkg::pts_cmd_t cmd,
	input  wire pts_pkg::pts_cfg_t cfg,
	pts_result_if.source           results
);

	localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int CMP_W  = (CNT_W > pts_pkg::SLOTS_W) ? CNT_W : pts_pkg::SLOTS_W;

	typedef enum logic [2:0] {B_IDLE, B_EXEC, B_RD, B_EV, B_END} back_state_t;

	back_state_t                      state_q;
	pts_pkg::pts_cmd_t                cmd_q;
	pts_pkg::pts_res_t                res_q;
	logic                             out_valid_q;
	logic [CNT_W-1:0]                 count_q;
	logic [MAX_SLOTS-1:0]             enabled_q;
	logic [SLOT_W-1:0]                idx_q;
	logic [SLOT_W-1:0]                pend_idx_q;
	logic                             pend_valid_q;
	logic [pts_pkg::RES_CNT_W-1:0]    n_q;

	logic [pts_pkg::PERIOD_W-1:0]     period_mem [MAX_SLOTS];
	logic [pts_pkg::ELAPSED_W-1:0]    elapsed_mem [MAX_SLOTS];
	logic [pts_pkg::PERIOD_W-1:0]     per_rd_q;
	logic [pts_pkg::ELAPSED_W-1:0]    ela_rd_q;

	logic                             per_we;
	logic [SLOT_W-1:0]                per_wa;
	logic [pts_pkg::PERIOD_W-1:0]     per_wd;
	logic                             ela_we;
	logic [SLOT_W-1:0]                ela_wa;
	logic [pts_pkg::ELAPSED_W-1:0]    ela_wd;

	logic                             load_ok;
	logic                             res_load;
	logic                             en_cur;
	logic [pts_pkg::ELAPSED_W-1:0]    sum;
	logic                             fire;
	logic                             emit;
	logic                             stall_ev;
	logic                             last_slot;
	logic                             task_ok;
	logic                             reg_ok;
	logic [CMP_W-1:0]                 limit;
	logic [SLOT_W-1:0]                task_slot;
	logic [pts_pkg::REPLY_W-1:0]      reply;

	assign cmd_ready          = (state_q == B_IDLE);
	assign results.valid      = out_valid_q;
	assign results.fired      = res_q.fired;
	assign results.slot_index = res_q.slot_index;
	assign results.reply      = res_q.reply;
	assign results.last       = res_q.last;

	assign load_ok   = !out_valid_q || results.ready;
	assign en_cur    = enabled_q[idx_q];
	assign sum       = ela_rd_q + pts_pkg::ELAPSED_W'(cfg.tick_ms);
	assign fire      = en_cur && (sum >= pts_pkg::ELAPSED_W'(per_rd_q));
	assign emit      = fire && (n_q < pts_pkg::RES_CNT_W'(pts_pkg::MAX_RESULTS));
	assign stall_ev  = emit && pend_valid_q && !load_ok;
	assign res_load  = (state_q == B_EXEC && load_ok) ||
	                   (state_q == B_EV && !stall_ev && emit && pend_valid_q) ||
	                   (state_q == B_END && load_ok);
	assign last_slot = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign task_slot = SLOT_W'(cmd_q.task_number - 1'b1);
	assign task_ok   = (cmd_q.task_number != '0) &&
	                   (CMP_W'(cmd_q.task_number) <= CMP_W'(count_q));
	assign limit     = (CMP_W'(cfg.slots_in_use) > CMP_W'(MAX_SLOTS)) ?
	                   CMP_W'(MAX_SLOTS) : CMP_W'(cfg.slots_in_use);
	assign reg_ok    = cmd_q.mult_ok && cmd_q.ge_tick && (CMP_W'(count_q) < limit);

	always_comb begin
		unique case (cmd_q.kind)
			pts_pkg::KIND_REGISTER:   reply = reg_ok ? pts_pkg::REPLY_W'(count_q + 1'b1) : '0;
			pts_pkg::KIND_STOP:       reply = pts_pkg::REPLY_W'(task_ok);
			pts_pkg::KIND_START:      reply = pts_pkg::REPLY_W'(task_ok);
			pts_pkg::KIND_SET_PERIOD: reply = pts_pkg::REPLY_W'(task_ok && cmd_q.mult_ok);
			default:                  reply = '0;
		endcase
	end

	always_comb begin
		per_we = 1'b0;
		per_wa = task_slot;
		per_wd = cmd_q.period_ms;
		ela_we = 1'b0;
		ela_wa = idx_q;
		ela_wd = fire ? '0 : sum;
		if (state_q == B_EXEC && load_ok) begin
			if (cmd_q.kind == pts_pkg::KIND_REGISTER && reg_ok) begin
				per_we = 1'b1;
				per_wa = SLOT_W'(count_q);
				ela_we = 1'b1;
				ela_wa = SLOT_W'(count_q);
				ela_wd = '0;
			end else if (cmd_q.kind == pts_pkg::KIND_SET_PERIOD && task_ok && cmd_q.mult_ok) begin
				per_we = 1'b1;
			end
		end else if (state_q == B_EV && !stall_ev && en_cur) begin
			ela_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (per_we) begin
			period_mem[per_wa] <= per_wd;
		end
		per_rd_q <= period_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (ela_we) begin
			elapsed_mem[ela_wa] <= ela_wd;
		end
		ela_rd_q <= elapsed_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			out_valid_q  <= 1'b0;
			count_q      <= '0;
			enabled_q    <= '0;
			idx_q        <= '0;
			pend_idx_q   <= '0;
			pend_valid_q <= 1'b0;
			n_q          <= '0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && !results.ready);
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						if (cmd.kind == pts_pkg::KIND_TICK) begin
							idx_q        <= '0;
							n_q          <= '0;
							pend_idx_q   <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= (count_q == '0) ? B_END : B_RD;
						end else begin
							state_q <= B_EXEC;
						end
					end
				end
				B_EXEC: begin
					if (load_ok) begin
						res_q       <= '{fired: 1'b0, slot_index: '0, reply: reply, last: 1'b1};
						if (cmd_q.kind == pts_pkg::KIND_REGISTER && reg_ok) begin
							enabled_q[SLOT_W'(count_q)] <= 1'b1;
							count_q                     <= count_q + 1'b1;
						end else if (cmd_q.kind == pts_pkg::KIND_STOP && task_ok) begin
							enabled_q[task_slot] <= 1'b0;
						end else if (cmd_q.kind == pts_pkg::KIND_START && task_ok) begin
							enabled_q[task_slot] <= 1'b1;
						end
						state_q <= B_IDLE;
					end
				end
				B_RD: begin
					state_q <= B_EV;
				end
				B_EV: begin
					if (!stall_ev) begin
						if (emit && pend_valid_q) begin
							res_q <= '{fired: 1'b1, slot_index: pts_pkg::IDX_OUT_W'(pend_idx_q),
							           reply: '0, last: 1'b0};
						end
						if (emit) begin
							pend_idx_q   <= idx_q;
							pend_valid_q <= 1'b1;
							n_q          <= n_q + 1'b1;
						end
						if (last_slot) begin
							state_q <= B_END;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= B_RD;
						end
					end
				end
				B_END: begin
					if (load_ok) begin
						res_q <= '{fired: pend_valid_q,
						           slot_index: pts_pkg::IDX_OUT_W'(pend_idx_q),
						           reply: '0, last: 1'b1};
						pend_valid_q <= 1'b0;
						state_q      <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### tb/tb_periodic_task_tick_scheduler_unit.sv
// Self-checking testbench for the periodic task tick scheduler: directed and random requests.
`default_nettype none

module tb_periodic_task_tick_scheduler_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_COUNT = 8;
	localparam logic [pts_pkg::KIND_W-1:0] KIND_RESERVED_LO = 3'd5;
	localparam logic [pts_pkg::KIND_W-1:0] KIND_RESERVED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	pts_item_if   items_ch();
	pts_result_if results_ch();
	pts_cfg_if    cfg_ch();

	periodic_task_tick_scheduler_unit #(.MAX_SLOTS(SLOT_COUNT)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_ch),
		.results(results_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [pts_pkg::PERIOD_W-1:0]  shadow_period [SLOT_COUNT];
	logic [pts_pkg::ELAPSED_W-1:0] shadow_elapsed[SLOT_COUNT];
	bit                            shadow_enabled[SLOT_COUNT];
	int unsigned                   shadow_count;
	logic [pts_pkg::TICK_W-1:0]    tick_len;
	logic [pts_pkg::SLOTS_W-1:0]   slot_cap;

	pts_pkg::pts_res_t awaited_results[$];
	pts_pkg::pts_res_t head_result;
	pts_pkg::pts_res_t seen_result;
	int                mismatches;
	bit                steady_flow;

	function automatic bit is_tick_multiple(input logic [pts_pkg::PERIOD_W-1:0] period);
		return tick_len != 0 && (period % tick_len) == 0;
	endfunction

	function automatic bit is_live_slot(input logic [pts_pkg::TASK_W-1:0] task_no);
		return task_no != 0 && task_no <= shadow_count;
	endfunction

	function automatic void apply_request(input logic [pts_pkg::KIND_W-1:0] kind,
			input logic [pts_pkg::TASK_W-1:0] task_no,
			input logic [pts_pkg::PERIOD_W-1:0] period);
		pts_pkg::pts_res_t           held;
		bit                          have_held;
		int unsigned                 cap;
		logic [pts_pkg::REPLY_W-1:0] reply;
		held = '0;
		have_held = 1'b0;
		reply = '0;
		cap = (slot_cap > SLOT_COUNT) ? SLOT_COUNT : slot_cap;
		case (kind)
			pts_pkg::KIND_TICK: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_enabled[i]) begin
						shadow_elapsed[i] = shadow_elapsed[i] +
							pts_pkg::ELAPSED_W'(tick_len);
						if (shadow_elapsed[i] >= {1'b0, shadow_period[i]}) begin
							shadow_elapsed[i] = '0;
							if (have_held)
								awaited_results.push_back(held);
							held = '{fired: 1'b1, slot_index: pts_pkg::IDX_OUT_W'(i),
								reply: '0, last: 1'b0};
							have_held = 1'b1;
						end
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					awaited_results.push_back(held);
				end else begin
					awaited_results.push_back('{fired: 1'b0, slot_index: '0, reply: '0, last: 1'b1});
				end
				return;
			end
			pts_pkg::KIND_REGISTER: begin
				if (is_tick_multiple(period) && period >= tick_len && shadow_count < cap) begin
					shadow_period[shadow_count]  = period;
					shadow_elapsed[shadow_count] = '0;
					shadow_enabled[shadow_count] = 1'b1;
					shadow_count++;
					reply = pts_pkg::REPLY_W'(shadow_count);
				end
			end
			pts_pkg::KIND_STOP: begin
				if (is_live_slot(task_no)) begin
					shadow_enabled[task_no - 1] = 1'b0;
					reply = pts_pkg::REPLY_W'(1);
				end
			end
			pts_pkg::KIND_START: begin
				if (is_live_slot(task_no)) begin
					shadow_enabled[task_no - 1] = 1'b1;
					reply = pts_pkg::REPLY_W'(1);
				end
			end
			pts_pkg::KIND_SET_PERIOD: begin
				if (is_live_slot(task_no) && is_tick_multiple(period)) begin
					shadow_period[task_no - 1] = period;
					reply = pts_pkg::REPLY_W'(1);
				end
			end
			default: begin
			end
		endcase
		awaited_results.push_back('{fired: 1'b0, slot_index: '0, reply: reply, last: 1'b1});
	endfunction

	task automatic send_request(input logic [pts_pkg::KIND_W-1:0] kind,
			input logic [pts_pkg::TASK_W-1:0] task_no,
			input logic [pts_pkg::PERIOD_W-1:0] period);
		@(negedge clk);
		while (!steady_flow && $urandom_range(0, 99) < 28) begin
			items_ch.valid = 1'b0;
			@(negedge clk);
		end
		items_ch.valid       = 1'b1;
		items_ch.kind        = kind;
		items_ch.task_number = task_no;
		items_ch.period_ms   = period;
		do @(posedge clk); while (!items_ch.ready);
		apply_request(kind, task_no, period);
	endtask

	task automatic drain_results();
		@(negedge clk);
		items_ch.valid = 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [pts_pkg::CFG_IDX_W-1:0] index,
			input logic [pts_pkg::CFG_DATA_W-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = index;
		cfg_ch.data  = data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (index == pts_pkg::CFG_TICK_MS)
			tick_len = data;
		else if (index == pts_pkg::CFG_SLOTS_IN_USE)
			slot_cap = data[pts_pkg::SLOTS_W-1:0];
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic logic [pts_pkg::TASK_W-1:0] pick_task();
		if ($urandom_range(0, 99) < 85)
			return pts_pkg::TASK_W'($urandom_range(1, (shadow_count == 0) ? 1 : shadow_count));
		return pts_pkg::TASK_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [pts_pkg::PERIOD_W-1:0] pick_period();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tick_len == 0 || r >= 90)
			return pts_pkg::PERIOD_W'($urandom_range(0, 65535));
		if (r < 70)
			return pts_pkg::PERIOD_W'(tick_len * $urandom_range(0, 6));
		if (r < 80 || tick_len == 1)
			return 16'hFFFF - (16'hFFFF % tick_len);
		return pts_pkg::PERIOD_W'(tick_len * $urandom_range(1, 3) +
			$urandom_range(1, tick_len - 1));
	endfunction

	task automatic test_register_rules();
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd100);
		write_register(pts_pkg::CFG_TICK_MS, 8'd10);
		write_register(pts_pkg::CFG_SLOTS_IN_USE, 8'd2);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd5);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd15);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'hFFFF);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd65530);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd20);
		write_register(pts_pkg::CFG_SLOTS_IN_USE, 8'd12);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd0);
		send_request(pts_pkg::KIND_REGISTER, 4'd15, 16'd20);
	endtask

	task automatic test_slot_control();
		send_request(pts_pkg::KIND_STOP, 4'd0, 16'd0);
		send_request(pts_pkg::KIND_STOP, 4'd4, 16'd0);
		send_request(pts_pkg::KIND_START, 4'd15, 16'd0);
		send_request(pts_pkg::KIND_SET_PERIOD, 4'd9, 16'd10);
		send_request(pts_pkg::KIND_STOP, 4'd2, 16'd0);
		send_request(pts_pkg::KIND_START, 4'd2, 16'hFFFF);
		send_request(pts_pkg::KIND_STOP, 4'd1, 16'd0);
		send_request(pts_pkg::KIND_SET_PERIOD, 4'd3, 16'd0);
		send_request(pts_pkg::KIND_SET_PERIOD, 4'd1, 16'd25);
		send_request(pts_pkg::KIND_SET_PERIOD, 4'd1, 16'd30);
		for (logic [pts_pkg::KIND_W-1:0] k = KIND_RESERVED_LO;
				k <= KIND_RESERVED_HI && k != 0; k++)
			send_request(k, pts_pkg::TASK_W'($urandom_range(0, 15)),
				pts_pkg::PERIOD_W'($urandom_range(0, 65535)));
	endtask

	task automatic test_tick_firing();
		send_request(pts_pkg::KIND_START, 4'd1, 16'd0);
		repeat (4)
			send_request(pts_pkg::KIND_TICK, 4'd0, 16'd0);
	endtask

	task automatic test_zero_tick();
		write_register(pts_pkg::CFG_TICK_MS, 8'd0);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd0);
		send_request(pts_pkg::KIND_SET_PERIOD, 4'd3, 16'd0);
		send_request(pts_pkg::KIND_TICK, 4'd0, 16'd0);
		write_register(pts_pkg::CFG_TICK_MS, 8'd255);
		write_register(pts_pkg::CFG_SLOTS_IN_USE, 8'd0);
		send_request(pts_pkg::KIND_REGISTER, 4'd0, 16'd255);
		send_request(pts_pkg::KIND_TICK, 4'd0, 16'd0);
	endtask

	task automatic test_random_traffic(input logic [pts_pkg::TICK_W-1:0] tick_value,
			input logic [pts_pkg::CFG_DATA_W-1:0] cap_value, input int count);
		int unsigned r;
		write_register(pts_pkg::CFG_TICK_MS, tick_value);
		write_register(pts_pkg::CFG_SLOTS_IN_USE, cap_value);
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				send_request(pts_pkg::KIND_TICK, pts_pkg::TASK_W'($urandom_range(0, 15)),
					pts_pkg::PERIOD_W'($urandom_range(0, 65535)));
			else if (r < 55)
				send_request(pts_pkg::KIND_REGISTER, pts_pkg::TASK_W'($urandom_range(0, 15)),
					pick_period());
			else if (r < 65)
				send_request(pts_pkg::KIND_STOP, pick_task(),
					pts_pkg::PERIOD_W'($urandom_range(0, 65535)));
			else if (r < 77)
				send_request(pts_pkg::KIND_START, pick_task(),
					pts_pkg::PERIOD_W'($urandom_range(0, 65535)));
			else if (r < 94)
				send_request(pts_pkg::KIND_SET_PERIOD, pick_task(), pick_period());
			else
				send_request(KIND_RESERVED_LO + pts_pkg::KIND_W'($urandom_range(0, 2)),
					pts_pkg::TASK_W'($urandom_range(0, 15)),
					pts_pkg::PERIOD_W'($urandom_range(0, 65535)));
		end
	endtask

	function automatic bit field_differs(input string name, input int want, input int got);
		if (want == got)
			return 1'b0;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			seen_result = '{fired: results_ch.fired, slot_index: results_ch.slot_index,
				reply: results_ch.reply, last: results_ch.last};
			if (awaited_results.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %p", $time, seen_result);
				mismatches++;
			end else begin
				head_result = awaited_results.pop_front();
				if (field_differs("fired", head_result.fired, seen_result.fired) |
						field_differs("slot_index", head_result.slot_index, seen_result.slot_index) |
						field_differs("reply", head_result.reply, seen_result.reply) |
						field_differs("last", head_result.last, seen_result.last))
					mismatches++;
			end
		end
	end

	always @(negedge clk)
		results_ch.ready = steady_flow || ($urandom_range(0, 99) >= 28);

	initial begin
		#5_000_000;
		$display("tb_periodic_task_tick_scheduler_unit failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		items_ch.valid = 1'b0;
		items_ch.kind = pts_pkg::KIND_TICK;
		items_ch.task_number = '0;
		items_ch.period_ms = '0;
		results_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = pts_pkg::CFG_TICK_MS;
		cfg_ch.data = '0;
		mismatches = 0;
		steady_flow = 1'b0;
		tick_len = pts_pkg::TICK_MS_RESET;
		slot_cap = pts_pkg::SLOTS_IN_USE_RESET;
		shadow_count = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			shadow_period[i] = '0;
			shadow_elapsed[i] = '0;
			shadow_enabled[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_rules();
		test_slot_control();
		test_tick_firing();
		test_zero_tick();
		test_random_traffic(8'd1, 8'd8, 63);
		test_random_traffic(8'd255, 8'd5, 63);
		test_random_traffic(pts_pkg::TICK_W'($urandom_range(1, 255)),
			pts_pkg::CFG_DATA_W'($urandom_range(0, 8)), 63);
		steady_flow = 1'b1;
		test_random_traffic(8'd100, 8'd8, 63);
		steady_flow = 1'b0;

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("tb_periodic_task_tick_scheduler_unit passed");
		else
			$display("tb_periodic_task_tick_scheduler_unit failed");
		$finish;
	end
endmodule

`default_nettype wire

### files.f
hw/rtl/pts_pkg.sv
hw/rtl/pts_ifs.sv
hw/rtl/pts_front.sv
hw/rtl/pts_fifo.sv
hw/rtl/pts_back.sv
hw/rtl/periodic_task_tick_scheduler_unit.sv
tb/tb_periodic_task_tick_scheduler_unit.sv
